// File: rtl/binary_search_engine_macros.svh
// Assertion macros shared by the binary search engine RTL.
// Depends on nothing; the asserting modules provide clk_i and rst_ni.
`ifndef BINARY_SEARCH_ENGINE_MACROS_SVH
`define BINARY_SEARCH_ENGINE_MACROS_SVH
`ifndef SYNTH
`define BSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BSE_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`else
`define BSE_ASSERT(label, prop, msg)
`define BSE_ASSERT_CLK(label, clk, rst_n, prop, msg)
`endif
`endif

// File: rtl/bse_pkg.sv
// Types and constants of the binary search engine.
// Depends on nothing; used by binary_search_engine, bse_ctrl and the testbench.
package bse_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned BND_W       = IDX_W + 1;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned IN_IDX_W    = 6;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(64);

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef struct packed {
    logic                     func;
    logic [IN_IDX_W-1:0]      entry_index;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] search_key;
  } bse_req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } bse_rsp_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } bse_ram_port_t;

endpackage

// File: rtl/binary_search_engine.sv
// Top level of the binary search engine: configuration register, result register,
// table memory and search sequencer. Depends on bse_pkg, bse_ram and bse_ctrl.
//
// The engine keeps a table of signed 32-bit words in a synchronous memory and looks
// keys up in it by binary search over entries 0 to entry_count-1 (a count above the
// table depth is taken as the depth). A write beat stores one word and produces no
// result; the engine stays idle, ready for the next beat. A search beat produces
// one result beat with a found flag and the matching position (zero on a miss).
// Each probe takes a memory read state and a compare state, and a search makes at
// most 7 probes for a full table. The finished result waits in an output register,
// so the next beat is taken meanwhile.
// The table is not cleared by reset; entries must be written before they are probed.
module binary_search_engine import bse_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bse_req_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bse_rsp_t           out_data_o
);

  logic [COUNT_W-1:0] count_q;
  logic               out_valid_q;
  bse_rsp_t           out_data_q;
  logic               rsp_valid;
  logic               rsp_ready;
  bse_rsp_t           rsp;
  bse_ram_port_t      ram_port;
  logic [DATA_W-1:0]  ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  assign rsp_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ready && rsp_valid) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  bse_ram #(
    .Width (DATA_W),
    .Depth (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_port.we),
    .waddr_i (ram_port.waddr),
    .wdata_i (ram_port.wdata),
    .re_i    (ram_port.re),
    .raddr_i (ram_port.raddr),
    .rdata_o (ram_rdata)
  );

  bse_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (in_valid_i),
    .req_ready_o   (in_ready_o),
    .req_i         (in_data_i),
    .entry_count_i (count_q),
    .rsp_valid_o   (rsp_valid),
    .rsp_ready_i   (rsp_ready),
    .rsp_o         (rsp),
    .ram_o         (ram_port),
    .ram_rdata_i   (ram_rdata)
  );

endmodule

// File: rtl/bse_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module bse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bse_ctrl.sv
// Search sequencer: takes request beats, writes the table and runs the probe loop.
// Depends on bse_pkg and binary_search_engine_macros.svh.
`include "binary_search_engine_macros.svh"
module bse_ctrl import bse_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  bse_req_t            req_i,
  input  logic [COUNT_W-1:0]  entry_count_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output bse_rsp_t            rsp_o,
  output bse_ram_port_t       ram_o,
  input  logic [DATA_W-1:0]   ram_rdata_i
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]               state_q, state_d;
  logic [BND_W-1:0]         lo_q, lo_d;
  logic [BND_W-1:0]         hi_q, hi_d;
  logic [IDX_W-1:0]         mid_q, mid_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  logic                     found_q, found_d;
  logic [POS_W-1:0]         pos_q, pos_d;
  logic [BND_W:0]           mid_sum;
  logic [IDX_W-1:0]         mid;
  logic signed [DATA_W-1:0] probe;
  logic                     accept;

  // The upper bound is held exclusive, so the range is empty when lo equals hi.
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (BND_W + 1)'(1);
  assign mid     = mid_sum[IDX_W:1];
  assign probe   = signed'(ram_rdata_i);
  assign accept  = req_valid_i && req_ready_o;

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    key_d       = key_q;
    found_d     = found_q;
    pos_d       = pos_q;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    ram_o       = '0;
    ram_o.waddr = IDX_W'(req_i.entry_index);
    ram_o.wdata = req_i.entry_value;
    ram_o.raddr = mid;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (accept) begin
          if (req_i.func == FUNC_WRITE) begin
            ram_o.we = 1'b1;
          end else begin
            key_d = req_i.search_key;
            lo_d  = '0;
            if (entry_count_i > COUNT_W'(TABLE_DEPTH)) begin
              hi_d = BND_W'(TABLE_DEPTH);
            end else begin
              hi_d = BND_W'(entry_count_i);
            end
            state_d = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (lo_q < hi_q) begin
          ram_o.re = 1'b1;
          mid_d    = mid;
          state_d  = ST_CMP;
        end else begin
          found_d = 1'b0;
          pos_d   = '0;
          state_d = ST_DONE;
        end
      end
      ST_CMP: begin
        priority if (key_q == probe) begin
          found_d = 1'b1;
          pos_d   = POS_W'(mid_q);
          state_d = ST_DONE;
        end else if (key_q < probe) begin
          hi_d    = {1'b0, mid_q};
          state_d = ST_PROBE;
        end else begin
          lo_d    = {1'b0, mid_q} + BND_W'(1);
          state_d = ST_PROBE;
        end
      end
      ST_DONE: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rsp_o.found    = found_q;
  assign rsp_o.position = pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    key_q   <= key_d;
    found_q <= found_d;
    pos_q   <= pos_d;
  end

  `BSE_ASSERT(a_miss_pos_zero, rsp_valid_o && !rsp_o.found |-> rsp_o.position == '0, "Miss beat carries a non-zero position.")
  `BSE_ASSERT(a_cmp_after_read, state_q == ST_CMP |-> $past(ram_o.re), "Compare without a table read in the previous cycle.")
  `BSE_ASSERT_CLK(a_write_idle, clk_i, rst_ni, ram_o.we |-> state_q == ST_IDLE && !ram_o.re, "Table write outside the idle state.")

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for binary_search_engine: table writes and key searches are
// sent through a queue-fed driver and every search result is checked by a monitor.
// Depends on bse_pkg and binary_search_engine.
module tb_top import bse_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 24;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_GAP        = 13;
  localparam int NUM_PHASES     = 9;
  localparam int PRESSURE_PHASE = 5;
  localparam int REPORT_LIMIT   = 10;

  localparam logic signed [DATA_W-1:0] KEY_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] KEY_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  bse_req_t           in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  bse_rsp_t           out_data_o;

  bse_req_t                 queued_reqs[$];
  bse_rsp_t                 expected_lookups[$];
  logic signed [DATA_W-1:0] shadow_table [TABLE_DEPTH];
  logic [COUNT_W-1:0]       shadow_count = COUNT_RESET;
  logic signed [DATA_W-1:0] plan_table [TABLE_DEPTH];

  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  bit hold_go    = 1'b0;
  logic rx_hold  = 1'b0;

  bit offering;
  int send_gap;
  int recv_gap;
  int idle_cycles;
  int results_seen;
  int mismatches;
  int writes_sent;
  int searches_sent;
  int hits_seen;
  int counts_tried;

  binary_search_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #(CLK_PERIOD/2) clk_i = ~clk_i;

  function automatic bse_rsp_t search_table(logic signed [DATA_W-1:0] key);
    int span;
    int lo;
    int hi;
    int mid;
    bse_rsp_t rsp;
    rsp = '0;
    span = int'(shadow_count);
    if (span > int'(TABLE_DEPTH)) span = int'(TABLE_DEPTH);
    lo = 0;
    hi = span - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (key == shadow_table[mid]) begin
        rsp.found = 1'b1;
        rsp.position = POS_W'(mid);
        break;
      end else if (key < shadow_table[mid]) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return rsp;
  endfunction

  function automatic void take_request(bse_req_t req);
    bse_rsp_t rsp;
    if (req.func == FUNC_SEARCH) begin
      rsp = search_table(req.search_key);
      expected_lookups.push_back(rsp);
      searches_sent++;
      if (rsp.found) hits_seen++;
    end else begin
      shadow_table[req.entry_index] = req.entry_value;
      writes_sent++;
    end
  endfunction

  function automatic void check_result(bse_rsp_t got);
    bse_rsp_t want;
    results_seen++;
    if (expected_lookups.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("result %0d arrived with no search outstanding: found=%0b position=%0d",
                 results_seen, got.found, got.position);
    end else begin
      want = expected_lookups.pop_front();
      if (got.found !== want.found || got.position !== want.position) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result %0d: expected found=%0b position=%0d, got found=%0b position=%0d",
                   results_seen, want.found, want.position, got.found, got.position);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      offering = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        take_request(in_data_i);
        offering = 1'b0;
        send_gap = tx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (queued_reqs.size() > 0) begin
          in_data_i <= queued_reqs.pop_front();
          offering = 1'b1;
        end
      end
      in_valid_i <= offering;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_result(out_data_o);
        recv_gap = rx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
      end else if (recv_gap > 0) begin
        recv_gap--;
      end
      out_ready_i <= !rx_hold && recv_gap == 0;
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic wait_for_idle();
    do @(negedge clk_i);
    while (queued_reqs.size() != 0 || in_valid_i || expected_lookups.size() != 0);
  endtask

  task automatic set_entry_count(logic [COUNT_W-1:0] value);
    wait_for_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    shadow_count = value;
    cfg_we_i <= 1'b0;
    counts_tried++;
    @(negedge clk_i);
  endtask

  task automatic push_write(int idx, logic signed [DATA_W-1:0] value);
    bse_req_t req;
    req.func        = FUNC_WRITE;
    req.entry_index = IN_IDX_W'(idx);
    req.entry_value = value;
    req.search_key  = $urandom;
    plan_table[idx] = value;
    queued_reqs.push_back(req);
  endtask

  task automatic push_search(logic signed [DATA_W-1:0] key);
    bse_req_t req;
    req.func        = FUNC_SEARCH;
    req.entry_index = IN_IDX_W'($urandom);
    req.entry_value = $urandom;
    req.search_key  = key;
    queued_reqs.push_back(req);
  endtask

  task automatic load_sorted_table(int unsigned max_step, bit pin_ends);
    longint level;
    level = longint'(KEY_MIN);
    if (!pin_ends) level = level + longint'($urandom_range(0, 32'hF000_0000));
    for (int i = 0; i < int'(TABLE_DEPTH); i++) begin
      if (i > 0) level = level + longint'($urandom_range(0, max_step));
      if (level > longint'(KEY_MAX) || (pin_ends && i == int'(TABLE_DEPTH) - 1))
        level = longint'(KEY_MAX);
      push_write(i, level[DATA_W-1:0]);
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_key();
    int span;
    int slot;
    int unsigned roll;
    span = int'(shadow_count);
    if (span > int'(TABLE_DEPTH) || span == 0) span = int'(TABLE_DEPTH);
    slot = $urandom_range(0, span - 1);
    roll = $urandom_range(0, 99);
    if (roll < 60) return plan_table[slot];
    if (roll < 70) return plan_table[slot] + 1;
    if (roll < 80) return plan_table[slot] - 1;
    if (roll < 92) return $urandom;
    if (roll < 96) return KEY_MIN;
    return KEY_MAX;
  endfunction

  initial begin
    logic [COUNT_W-1:0] phase_counts [NUM_PHASES];
    int unsigned        step_sizes [5];
    int                 slot;
    int                 burst;

    step_sizes = '{1, 3, 1000, 32'h0010_0000, 32'h0400_0000};
    phase_counts = '{COUNT_W'(64), COUNT_W'(1), COUNT_W'(127), COUNT_W'(0), COUNT_W'(2),
                     COUNT_W'(63), COUNT_W'($urandom_range(1, 64)),
                     COUNT_W'($urandom_range(65, 127)), COUNT_W'(64)};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    set_entry_count(COUNT_W'(64));
    for (int i = 0; i < int'(TABLE_DEPTH); i++) begin
      if (i == 0) push_write(i, KEY_MIN);
      else if (i == int'(TABLE_DEPTH) - 1) push_write(i, KEY_MAX);
      else if (i == 41) push_write(i, plan_table[40]);
      else push_write(i, i * 1000 - 30000);
    end
    push_search(KEY_MIN);
    push_search(KEY_MAX);
    push_search(plan_table[31]);
    push_search(plan_table[15]);
    push_search(plan_table[47]);
    push_search(plan_table[1]);
    push_search(plan_table[62]);
    push_search(plan_table[40]);
    push_search(plan_table[10] + 1);
    push_search(KEY_MIN + 1);
    push_search(KEY_MAX - 1);

    set_entry_count(COUNT_W'(0));
    push_search(plan_table[31]);
    push_search(KEY_MIN);

    set_entry_count(COUNT_W'(127));
    push_search(plan_table[63]);
    push_search(plan_table[20]);

    set_entry_count(COUNT_W'(1));
    push_search(plan_table[0]);
    push_search(plan_table[31]);

    set_entry_count(COUNT_W'(64));
    push_write(31, KEY_MAX);
    push_search(KEY_MAX);
    push_search(plan_table[40]);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_entry_count(phase_counts[ph]);
      tx_idle_en = (ph == 0 || ph == PRESSURE_PHASE) ? 1'b0 : 1'($urandom_range(0, 1));
      rx_idle_en = (ph == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      if (ph == PRESSURE_PHASE) rx_idle_en = 1'b1;
      load_sorted_table(step_sizes[$urandom_range(0, 4)], 1'($urandom_range(0, 1)));
      burst = (phase_counts[ph] == 0) ? 20 : 50;
      for (int n = 0; n < burst; n++) begin
        if ($urandom_range(0, 99) < 6) begin
          slot = $urandom_range(0, int'(TABLE_DEPTH) - 1);
          if ($urandom_range(0, 1)) push_write(slot, plan_table[slot]);
          else push_write(slot, $urandom);
        end else begin
          push_search(pick_key());
        end
      end
      if (ph == PRESSURE_PHASE) hold_go = 1'b1;
    end

    wait_for_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Covered %0d table writes and %0d searches (%0d hits) under %0d entry counts,",
             writes_sent, searches_sent, hits_seen, counts_tried);
    $display("including empty, single, saturated and unsorted tables and a long output stall.");
    if (mismatches == 0 && expected_lookups.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, expected_lookups.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/bse_pkg.sv
rtl/bse_ram.sv
rtl/bse_ctrl.sv
rtl/binary_search_engine.sv
verif/tb_top.sv
